// File: hw/rtl/quadratic_root_solver_assert.svh
// Assertion macros for the quadratic root solver RTL.
`ifndef QUADRATIC_ROOT_SOLVER_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define QRS_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("quadratic_root_solver: check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define QRS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("quadratic_root_solver: check failed");

`endif

// File: hw/rtl/qrs_pkg.sv
// Shared types and constants of the quadratic root solver.
package qrs_pkg;

	typedef enum logic [1:0] {
		KIND_NONE    = 2'd0,
		KIND_SINGLE  = 2'd1,
		KIND_TWO     = 2'd2,
		KIND_COMPLEX = 2'd3
	} root_kind_t;

	localparam int unsigned ROOT_W = 40;

endpackage

// File: hw/rtl/qrs_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module qrs_isqrt #(
	parameter int RAD_W  = 66,
	parameter int SIDE_W = 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_vld,
	input  logic [RAD_W-1:0]      in_rad,
	input  logic [SIDE_W-1:0]     in_side,
	output logic                  out_vld,
	output logic [RAD_W/2-1:0]    out_root,
	output logic [SIDE_W-1:0]     out_side
);

	localparam int RTW = RAD_W / 2;
	localparam int RMW = RTW + 3;

	logic [RTW-1:0]    vld_q;
	logic [RMW-1:0]    rem_q  [RTW];
	logic [RTW-1:0]    root_q [RTW];
	logic [RAD_W-1:0]  rad_q  [RTW];
	logic [SIDE_W-1:0] side_q [RTW];

	for (genvar i = 0; i < RTW; i++) begin : g_step
		logic              vld_p;
		logic [RMW-1:0]    rem_p;
		logic [RTW-1:0]    root_p;
		logic [RAD_W-1:0]  rad_p;
		logic [SIDE_W-1:0] side_p;
		logic [RMW-1:0]    rem_n;
		logic [RMW-1:0]    trial;
		logic              ge;

		if (i == 0) begin : g_first
			assign vld_p  = in_vld;
			assign rem_p  = '0;
			assign root_p = '0;
			assign rad_p  = in_rad;
			assign side_p = in_side;
		end else begin : g_next
			assign vld_p  = vld_q[i-1];
			assign rem_p  = rem_q[i-1];
			assign root_p = root_q[i-1];
			assign rad_p  = rad_q[i-1];
			assign side_p = side_q[i-1];
		end

		// bring down the next two radicand bits and try root*4+1
		assign rem_n = {rem_p[RMW-3:0], rad_p[RAD_W-1 -: 2]};
		assign trial = {1'b0, root_p, 2'b01};
		assign ge    = (rem_n >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[i] <= 1'b0;
			end else if (en) begin
				vld_q[i] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[i]  <= ge ? (rem_n - trial) : rem_n;
				root_q[i] <= {root_p[RTW-2:0], ge};
				rad_q[i]  <= {rad_p[RAD_W-3:0], 2'b00};
				side_q[i] <= side_p;
			end
		end
	end

	assign out_vld  = vld_q[RTW-1];
	assign out_root = root_q[RTW-1];
	assign out_side = side_q[RTW-1];

endmodule

// File: hw/rtl/qrs_div.sv
// Pipelined two-lane signed divider, truncating toward zero, one quotient bit per stage.
module qrs_div #(
	parameter int NW     = 35,
	parameter int DW     = 17,
	parameter int SIDE_W = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_vld,
	input  logic signed [NW-1:0]  in_num0,
	input  logic signed [NW-1:0]  in_num1,
	input  logic signed [DW-1:0]  in_den,
	input  logic [SIDE_W-1:0]     in_side,
	output logic                  out_vld,
	output logic signed [NW-1:0]  out_quo0,
	output logic signed [NW-1:0]  out_quo1,
	output logic [SIDE_W-1:0]     out_side
);

	// magnitude stage
	logic                  vld_p_q;
	logic [1:0][NW-1:0]    mag_p_q;
	logic [DW-1:0]         dmag_p_q;
	logic [1:0]            neg_p_q;
	logic [SIDE_W-1:0]     side_p_q;

	logic [NW-1:0] mag0, mag1;
	logic [DW-1:0] dmag;

	assign mag0 = in_num0[NW-1] ? NW'(-in_num0) : in_num0;
	assign mag1 = in_num1[NW-1] ? NW'(-in_num1) : in_num1;
	assign dmag = in_den[DW-1] ? DW'(-in_den) : in_den;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_p_q <= 1'b0;
		end else if (en) begin
			vld_p_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_p_q  <= {mag1, mag0};
			dmag_p_q <= dmag;
			neg_p_q  <= {in_num1[NW-1] ^ in_den[DW-1], in_num0[NW-1] ^ in_den[DW-1]};
			side_p_q <= in_side;
		end
	end

	// restoring steps
	logic [NW-1:0]      vld_q;
	logic [1:0][DW-1:0] rem_q  [NW];
	logic [1:0][NW-1:0] sh_q   [NW];
	logic [DW-1:0]      dmag_q [NW];
	logic [1:0]         neg_q  [NW];
	logic [SIDE_W-1:0]  side_q [NW];

	for (genvar i = 0; i < NW; i++) begin : g_step
		logic               vld_p;
		logic [1:0][DW-1:0] rem_p;
		logic [1:0][NW-1:0] sh_p;
		logic [DW-1:0]      dm_p;
		logic [1:0]         neg_p;
		logic [SIDE_W-1:0]  side_p;
		logic [1:0][DW-1:0] rem_n;
		logic [1:0][NW-1:0] sh_n;

		if (i == 0) begin : g_first
			assign vld_p  = vld_p_q;
			assign rem_p  = '0;
			assign sh_p   = mag_p_q;
			assign dm_p   = dmag_p_q;
			assign neg_p  = neg_p_q;
			assign side_p = side_p_q;
		end else begin : g_next
			assign vld_p  = vld_q[i-1];
			assign rem_p  = rem_q[i-1];
			assign sh_p   = sh_q[i-1];
			assign dm_p   = dmag_q[i-1];
			assign neg_p  = neg_q[i-1];
			assign side_p = side_q[i-1];
		end

		for (genvar l = 0; l < 2; l++) begin : g_lane
			logic [DW:0] part;
			logic        ge;

			// shift in the next dividend bit, the quotient bit fills from below
			assign part     = {rem_p[l], sh_p[l][NW-1]};
			assign ge       = (part >= {1'b0, dm_p});
			assign rem_n[l] = ge ? DW'(part - {1'b0, dm_p}) : part[DW-1:0];
			assign sh_n[l]  = {sh_p[l][NW-2:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[i] <= 1'b0;
			end else if (en) begin
				vld_q[i] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[i]  <= rem_n;
				sh_q[i]   <= sh_n;
				dmag_q[i] <= dm_p;
				neg_q[i]  <= neg_p;
				side_q[i] <= side_p;
			end
		end
	end

	// sign restore stage
	logic                 vld_f_q;
	logic signed [NW-1:0] quo0_f_q, quo1_f_q;
	logic [SIDE_W-1:0]    side_f_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_f_q <= 1'b0;
		end else if (en) begin
			vld_f_q <= vld_q[NW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo0_f_q <= neg_q[NW-1][0] ? NW'(-sh_q[NW-1][0]) : sh_q[NW-1][0];
			quo1_f_q <= neg_q[NW-1][1] ? NW'(-sh_q[NW-1][1]) : sh_q[NW-1][1];
			side_f_q <= side_q[NW-1];
		end
	end

	assign out_vld  = vld_f_q;
	assign out_quo0 = quo0_f_q;
	assign out_quo1 = quo1_f_q;
	assign out_side = side_f_q;

endmodule

// File: hw/rtl/quadratic_root_solver.sv
// Top level of the quadratic root solver: roots of a*x^2 + b*x + c in fixed point.
//
// Input stream: one transaction per coefficient triple a, b, c (signed, COEF_WIDTH
// bits each). Output stream: one transaction per triple with the root kind in
// tuser and two signed 40-bit roots with FRAC_BITS fraction bits in tdata.
// Kinds: not quadratic (a is zero, both roots zero), single real root, two real
// roots, complex pair (real part, imaginary part with the sign of a).
// The square root is floored and the divisions truncate toward zero; roots that
// do not fit 40 bits saturate.
// Throughput: one triple per cycle while the receiver does not stall the output.
// Most of the pipeline depth is in the bit-per-stage square root and divider
// pipelines; RTW is the square root width and NW the dividend width.
// Reset clears every valid bit; the pipeline comes up empty and ready.
// When the receiver stalls with a result pending, the whole pipeline holds and
// s_axis_tready drops in the same cycle; nothing is lost or repeated.
`include "quadratic_root_solver_assert.svh"

module quadratic_root_solver #(
	parameter int COEF_WIDTH = 16,
	parameter int FRAC_BITS  = 16
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        s_axis_tvalid,
	output logic                                        s_axis_tready,
	// coef_a, coef_b, coef_c, zero fill
	input  logic [((3*COEF_WIDTH+7)/8)*8-1:0]           s_axis_tdata,
	output logic                                        m_axis_tvalid,
	input  logic                                        m_axis_tready,
	// root_one, root_two
	output logic [2*qrs_pkg::ROOT_W-1:0]                m_axis_tdata,
	// root_kind
	output logic [1:0]                                  m_axis_tuser
);

	localparam int CW     = COEF_WIDTH;
	localparam int DETW   = 2 * CW + 1;
	localparam int RAD_W0 = DETW + 2 * FRAC_BITS;
	localparam int RAD_W  = RAD_W0 + (RAD_W0 % 2);
	localparam int RTW    = RAD_W / 2;
	localparam int NBW    = CW + FRAC_BITS + 1;
	localparam int DENW   = CW + 1;
	localparam int NW     = ((NBW > RTW + 1) ? NBW : RTW + 1) + 1;
	localparam int SIDE_W = 2 + NBW + DENW;
	localparam int OW     = qrs_pkg::ROOT_W;

	logic en;

	// output register
	logic                   vld_q;
	qrs_pkg::root_kind_t    kind_q;
	logic signed [OW-1:0]   root_one_q, root_two_q;

	assign en            = !vld_q || m_axis_tready;
	assign s_axis_tready = en;

	// stage 1: capture
	logic                 vld_s1;
	logic signed [CW-1:0] a_s1, b_s1, c_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= s_axis_tdata[CW-1:0];
			b_s1 <= s_axis_tdata[2*CW-1:CW];
			c_s1 <= s_axis_tdata[3*CW-1:2*CW];
		end
	end

	// stage 2: products of magnitudes
	logic [CW-1:0]         am, bm, cm;
	logic signed [NBW-1:0] bx;

	assign am = a_s1[CW-1] ? CW'(-a_s1) : a_s1;
	assign bm = b_s1[CW-1] ? CW'(-b_s1) : b_s1;
	assign cm = c_s1[CW-1] ? CW'(-c_s1) : c_s1;
	assign bx = NBW'(b_s1);

	logic                   vld_s2;
	logic [2*CW-1:0]        b2_s2, p_s2;
	logic                   opp_s2, azero_s2;
	logic signed [NBW-1:0]  nb_s2;
	logic signed [DENW-1:0] den_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b2_s2    <= bm * bm;
			p_s2     <= am * cm;
			opp_s2   <= (c_s1 != '0) && (a_s1[CW-1] != c_s1[CW-1]);
			azero_s2 <= (a_s1 == '0);
			nb_s2    <= -(bx <<< FRAC_BITS);
			den_s2   <= {a_s1, 1'b0};
		end
	end

	// stage 3: discriminant and root kind
	logic [DETW-1:0]     four, b2x, det;
	logic                four_gt;
	qrs_pkg::root_kind_t kind_n;

	assign four    = DETW'({p_s2, 2'b00});
	assign b2x     = DETW'(b2_s2);
	assign four_gt = (four > b2x);

	always_comb begin
		if (opp_s2) begin
			det = b2x + four;
		end else if (four_gt) begin
			det = four - b2x;
		end else begin
			det = b2x - four;
		end
	end

	always_comb begin
		priority if (azero_s2) begin
			kind_n = qrs_pkg::KIND_NONE;
		end else if (!opp_s2 && four_gt) begin
			kind_n = qrs_pkg::KIND_COMPLEX;
		end else if (det == '0) begin
			kind_n = qrs_pkg::KIND_SINGLE;
		end else begin
			kind_n = qrs_pkg::KIND_TWO;
		end
	end

	logic                   vld_s3;
	logic [RAD_W-1:0]       rad_s3;
	qrs_pkg::root_kind_t    kind_s3;
	logic signed [NBW-1:0]  nb_s3;
	logic signed [DENW-1:0] den_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s3  <= RAD_W'(det) << (2 * FRAC_BITS);
			kind_s3 <= kind_n;
			nb_s3   <= nb_s2;
			den_s3  <= den_s2;
		end
	end

	// square root
	logic              sq_vld;
	logic [RTW-1:0]    sq_root;
	logic [SIDE_W-1:0] sq_side;

	qrs_isqrt #(
		.RAD_W  (RAD_W),
		.SIDE_W (SIDE_W)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s3),
		.in_rad   (rad_s3),
		.in_side  ({kind_s3, nb_s3, den_s3}),
		.out_vld  (sq_vld),
		.out_root (sq_root),
		.out_side (sq_side)
	);

	// stage 4: dividends
	qrs_pkg::root_kind_t    sq_kind;
	logic signed [NW-1:0]   nbx, sx;

	assign sq_kind = qrs_pkg::root_kind_t'(sq_side[SIDE_W-1 -: 2]);
	assign nbx     = NW'($signed(sq_side[DENW +: NBW]));
	assign sx      = NW'(sq_root);

	logic                   vld_s4;
	logic signed [NW-1:0]   n1_s4, n2_s4;
	logic signed [DENW-1:0] den_s4;
	qrs_pkg::root_kind_t    kind_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (sq_kind == qrs_pkg::KIND_COMPLEX) begin
				n1_s4 <= nbx;
				n2_s4 <= sx;
			end else begin
				n1_s4 <= nbx + sx;
				n2_s4 <= nbx - sx;
			end
			den_s4  <= sq_side[DENW-1:0];
			kind_s4 <= sq_kind;
		end
	end

	// division by 2a
	logic                 dv_vld;
	logic signed [NW-1:0] dv_q0, dv_q1;
	logic [1:0]           dv_side;

	qrs_div #(
		.NW     (NW),
		.DW     (DENW),
		.SIDE_W (2)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s4),
		.in_num0  (n1_s4),
		.in_num1  (n2_s4),
		.in_den   (den_s4),
		.in_side  (kind_s4),
		.out_vld  (dv_vld),
		.out_quo0 (dv_q0),
		.out_quo1 (dv_q1),
		.out_side (dv_side)
	);

	// fit to the 40-bit result fields
	logic signed [OW-1:0] r1, r2;

	if (NW > OW) begin : g_sat
		logic [NW-OW:0] hi1, hi2;

		assign hi1 = dv_q0[NW-1:OW-1];
		assign hi2 = dv_q1[NW-1:OW-1];
		assign r1  = (&hi1 || ~|hi1) ? dv_q0[OW-1:0] :
			(dv_q0[NW-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}});
		assign r2  = (&hi2 || ~|hi2) ? dv_q1[OW-1:0] :
			(dv_q1[NW-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}});
	end else begin : g_ext
		assign r1 = OW'(dv_q0);
		assign r2 = OW'(dv_q1);
	end

	qrs_pkg::root_kind_t dv_kind;

	assign dv_kind = qrs_pkg::root_kind_t'(dv_side);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_q <= dv_kind;
			if (dv_kind == qrs_pkg::KIND_NONE) begin
				root_one_q <= '0;
				root_two_q <= '0;
			end else begin
				root_one_q <= r1;
				root_two_q <= r2;
			end
		end
	end

	assign m_axis_tvalid = vld_q;
	assign m_axis_tuser  = kind_q;
	assign m_axis_tdata  = {root_two_q, root_one_q};

	`QRS_ASSERT_NEXT(a_accept_fills_s1, s_axis_tvalid && s_axis_tready, vld_s1)
	`QRS_ASSERT_IMPLIES(a_single_zero_det, vld_s3 && kind_s3 == qrs_pkg::KIND_SINGLE, rad_s3 == '0)
	`QRS_ASSERT_IMPLIES(a_none_is_zero, vld_q && kind_q == qrs_pkg::KIND_NONE, m_axis_tdata == '0)
	`QRS_ASSERT_IMPLIES(a_single_same, vld_q && kind_q == qrs_pkg::KIND_SINGLE, root_one_q == root_two_q)

endmodule

// File: dv/tb_quadratic_root_solver.sv
// Self-checking testbench for the quadratic root solver stream pipeline.
`timescale 1ns / 100ps

module tb_quadratic_root_solver;

	localparam int HOLD_CYCLES  = 400;
	localparam int STALL_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 100;
	localparam int N_RANDOM     = 935;

	typedef struct {
		qrs_pkg::root_kind_t kind;
		logic signed [39:0]  one;
		logic signed [39:0]  two;
	} roots_t;

	typedef struct {
		logic signed [15:0]  a;
		logic signed [15:0]  b;
		logic signed [15:0]  c;
		bit                  typed;
		roots_t              want;
	} coef_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;	// coef_a, coef_b, coef_c
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [79:0] m_axis_tdata;	// root_one, root_two
	logic [1:0]  m_axis_tuser;	// root_kind

	roots_t roots_due[$];
	roots_t typed_due[$];
	bit     typed_flag[$];
	int     err_count;
	int     quiet_cycles;
	int     send_idle_pct;
	int     recv_idle_pct;
	bit     hold_req;

	coef_row_t dir_tab [0:15] = '{
		'{16'sd0, 16'sd0, 16'sd0, 1'b1, '{qrs_pkg::KIND_NONE, 40'sd0, 40'sd0}},
		'{16'sd0, 16'sd32767, -16'sd32768, 1'b1, '{qrs_pkg::KIND_NONE, 40'sd0, 40'sd0}},
		'{16'sd0, -16'sd32768, 16'sd32767, 1'b1, '{qrs_pkg::KIND_NONE, 40'sd0, 40'sd0}},
		'{16'sd1, -16'sd2, 16'sd1, 1'b1, '{qrs_pkg::KIND_SINGLE, 40'sd65536, 40'sd65536}},
		'{16'sd2, 16'sd4, 16'sd2, 1'b1, '{qrs_pkg::KIND_SINGLE, -40'sd65536, -40'sd65536}},
		'{16'sd1, 16'sd0, -16'sd1, 1'b1, '{qrs_pkg::KIND_TWO, 40'sd65536, -40'sd65536}},
		'{16'sd1, 16'sd0, 16'sd1, 1'b1, '{qrs_pkg::KIND_COMPLEX, 40'sd0, 40'sd65536}},
		'{-16'sd1, 16'sd0, -16'sd1, 1'b1, '{qrs_pkg::KIND_COMPLEX, 40'sd0, -40'sd65536}},
		'{-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, '{qrs_pkg::KIND_NONE, 40'sd0, 40'sd0}},
		'{-16'sd32768, 16'sd32767, 16'sd32767, 1'b0, '{qrs_pkg::KIND_NONE, 40'sd0, 40'sd0}},
		'{16'sd32767, -16'sd32768, -16'sd32768, 1'b0, '{qrs_pkg::KIND_NONE, 40'sd0, 40'sd0}},
		'{16'sd32767, 16'sd32767, 16'sd32767, 1'b0, '{qrs_pkg::KIND_NONE, 40'sd0, 40'sd0}},
		'{-16'sd32768, 16'sd0, 16'sd32767, 1'b0, '{qrs_pkg::KIND_NONE, 40'sd0, 40'sd0}},
		'{16'sd32767, 16'sd0, 16'sd32767, 1'b0, '{qrs_pkg::KIND_NONE, 40'sd0, 40'sd0}},
		'{16'sd1, 16'sd32767, 16'sd0, 1'b0, '{qrs_pkg::KIND_NONE, 40'sd0, 40'sd0}},
		'{-16'sd1, -16'sd32768, 16'sd0, 1'b0, '{qrs_pkg::KIND_NONE, 40'sd0, 40'sd0}}
	};

	quadratic_root_solver dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic signed [39:0] clamp40(longint v);
		if (v > 64'sd549755813887) return 40'sd549755813887;
		if (v < -64'sd549755813888) return -40'sd549755813888;
		return v[39:0];
	endfunction

	// Exact discriminant, floored fixed-point root, truncating divisions.
	function automatic roots_t solve_roots(logic signed [15:0] a, logic signed [15:0] b,
			logic signed [15:0] c);
		longint sa, sb, sc, det, s, nb, den;
		logic [127:0] rad, rem, trial, root;
		roots_t r;
		sa = a;
		sb = b;
		sc = c;
		if (sa == 0) begin
			r.kind = qrs_pkg::KIND_NONE;
			r.one = '0;
			r.two = '0;
			return r;
		end
		det = sb * sb - 4 * sa * sc;
		rad = 128'(det < 0 ? -det : det) << 32;
		rem = '0;
		root = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = (rem << 2) | 128'(rad[2*i +: 2]);
			trial = (root << 2) | 128'd1;
			if (rem >= trial) begin
				rem = rem - trial;
				root = (root << 1) | 128'd1;
			end else begin
				root = root << 1;
			end
		end
		s = longint'(root[63:0]);
		nb = -sb * 65536;
		den = 2 * sa;
		if (det < 0) begin
			r.kind = qrs_pkg::KIND_COMPLEX;
			r.one = clamp40(nb / den);
			r.two = clamp40(s / den);
		end else if (det == 0) begin
			r.kind = qrs_pkg::KIND_SINGLE;
			r.one = clamp40(nb / den);
			r.two = r.one;
		end else begin
			r.kind = qrs_pkg::KIND_TWO;
			r.one = clamp40((nb + s) / den);
			r.two = clamp40((nb - s) / den);
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		err_count++;
	endtask

	// Predict on input transactions, check on output transactions.
	always @(posedge clk) begin
		roots_t want, got;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				want = solve_roots(s_axis_tdata[15:0], s_axis_tdata[31:16],
					s_axis_tdata[47:32]);
				if (typed_flag.size() > 0 && typed_flag.pop_front())
					want = typed_due.pop_front();
				roots_due.push_back(want);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.kind = qrs_pkg::root_kind_t'(m_axis_tuser);
				got.one = m_axis_tdata[39:0];
				got.two = m_axis_tdata[79:40];
				if (roots_due.size() == 0) begin
					report_mismatch("unexpected result, kind", got.kind, -1);
				end else begin
					want = roots_due.pop_front();
					if (got.kind != want.kind) report_mismatch("root_kind", got.kind, want.kind);
					if (got.one != want.one) report_mismatch("root_one", got.one, want.one);
					if (got.two != want.two) report_mismatch("root_two", got.two, want.two);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL quadratic_root_solver");
			$finish;
		end
	end

	// Receiver: random back-pressure, with one long hold-off on request.
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic send_coefs(logic signed [15:0] a, logic signed [15:0] b,
			logic signed [15:0] c);
		int gap;
		gap = 0;
		if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(1, 4);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {c, b, a};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	initial begin
		logic signed [15:0] a, b, c;
		int k, r, sel;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		err_count = 0;
		quiet_cycles = 0;
		hold_req = 1'b0;
		send_idle_pct = 38;
		recv_idle_pct = 64;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			typed_flag.push_back(dir_tab[i].typed);
			if (dir_tab[i].typed) typed_due.push_back(dir_tab[i].want);
			send_coefs(dir_tab[i].a, dir_tab[i].b, dir_tab[i].c);
		end

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == N_RANDOM / 3) begin
				send_idle_pct = 64;
				recv_idle_pct = 38;
			end else if (n == 2 * N_RANDOM / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (n == 100) hold_req = 1'b1;
			// pause until the pipeline has drained
			if (n == 500) begin
				s_axis_tvalid <= 1'b0;
				wait (roots_due.size() == 0);
				@(posedge clk);
			end
			sel = $urandom_range(9);
			if (sel < 4) begin
				a = 16'($urandom);
				b = 16'($urandom);
				c = 16'($urandom);
			end else if (sel < 6) begin
				a = $signed(5'($urandom));
				b = $signed(6'($urandom));
				c = $signed(5'($urandom));
			end else if (sel < 8) begin
				// perfect square: a*(x - r)^2
				k = $urandom_range(1, 40);
				r = $urandom_range(0, 40) - 20;
				if ($urandom_range(1)) k = -k;
				a = 16'(k);
				b = 16'(-2 * k * r);
				c = 16'(k * r * r);
			end else if (sel == 8) begin
				a = '0;
				b = 16'($urandom);
				c = 16'($urandom);
			end else begin
				a = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
				b = 16'($urandom);
				c = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
			end
			send_coefs(a, b, c);
		end
		s_axis_tvalid <= 1'b0;

		wait (roots_due.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("PASS quadratic_root_solver");
		else
			$display("FAIL quadratic_root_solver");
		$finish;
	end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/qrs_pkg.sv
hw/rtl/qrs_isqrt.sv
hw/rtl/qrs_div.sv
hw/rtl/quadratic_root_solver.sv
dv/tb_quadratic_root_solver.sv
